/* rtl/sls_pkg.sv */
// Package for the status LED sequencer: request/response types, config
// struct, event and mode codes, register indexes and reset values.
// No dependencies.
package sls_pkg;

   localparam int TIMER_BITS_DEFAULT    = 16;
   localparam int ERROR_TOGGLES_DEFAULT = 6;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLASH_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_PERIOD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_BLINK   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_BLINK   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_LEVEL    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLINK_LEVEL  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLASH_LEVEL  = 3'd6;

   localparam logic [15:0] RST_FLASH_LENGTH = 16'd100;
   localparam logic [15:0] RST_BASE_PERIOD  = 16'd50;
   localparam logic [15:0] RST_SLOW_BLINK   = 16'd500;
   localparam logic [15:0] RST_FAST_BLINK   = 16'd200;
   localparam logic [7:0]  RST_DIM_LEVEL    = 8'd10;
   localparam logic [7:0]  RST_BLINK_LEVEL  = 8'd25;
   localparam logic [7:0]  RST_FLASH_LEVEL  = 8'd50;

   // request op
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // event codes
   localparam logic [2:0] EV_AP_WAIT        = 3'd0;
   localparam logic [2:0] EV_AP_CONN        = 3'd1;
   localparam logic [2:0] EV_AP_DISC        = 3'd2;
   localparam logic [2:0] EV_STA_CONNECTING = 3'd3;
   localparam logic [2:0] EV_STA_CONN       = 3'd4;
   localparam logic [2:0] EV_ERROR          = 3'd5;
   localparam logic [2:0] EV_RX             = 3'd6;
   localparam logic [2:0] EV_TX             = 3'd7;

   // link modes
   localparam logic [2:0] MODE_AP_WAIT        = 3'd0;
   localparam logic [2:0] MODE_AP_CONN        = 3'd1;
   localparam logic [2:0] MODE_STA_CONNECTING = 3'd2;
   localparam logic [2:0] MODE_STA_CONN       = 3'd3;
   localparam logic [2:0] MODE_ERROR          = 3'd4;

   // base colors as {red, green, blue} on-bits; each lit channel is 255
   localparam logic [2:0] HUE_RED     = 3'b100;
   localparam logic [2:0] HUE_GREEN   = 3'b010;
   localparam logic [2:0] HUE_BLUE    = 3'b001;
   localparam logic [2:0] HUE_CYAN    = 3'b011;
   localparam logic [2:0] HUE_MAGENTA = 3'b101;

   typedef struct packed {
      logic       op;
      logic [2:0] event_code;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       refreshed;
   } rsp_type;

   typedef struct packed {
      logic [15:0] flash_length_ms;
      logic [15:0] base_period_ms;
      logic [15:0] slow_blink_ms;
      logic [15:0] fast_blink_ms;
      logic [7:0]  dim_level;
      logic [7:0]  blink_level;
      logic [7:0]  flash_level;
   } cfg_type;

   // 255*lvl/255 is lvl and 0*lvl/255 is 0, so scaling is a select
   function automatic logic [23:0] scale_color(input logic [2:0] mask, input logic [7:0] lvl);
      scale_color = {mask[2] ? lvl : 8'd0, mask[1] ? lvl : 8'd0, mask[0] ? lvl : 8'd0};
   endfunction

endpackage

/* rtl/sls_csr.sv */
// Configuration registers of the status LED sequencer.
// Depends on sls_pkg.
module sls_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [sls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sls_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output sls_pkg::cfg_type                 cfg
);

   sls_pkg::cfg_type cfg_ff;
   sls_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            sls_pkg::CSR_FLASH_LENGTH: cfg_in.flash_length_ms = csr_wdata;
            sls_pkg::CSR_BASE_PERIOD:  cfg_in.base_period_ms  = csr_wdata;
            sls_pkg::CSR_SLOW_BLINK:   cfg_in.slow_blink_ms   = csr_wdata;
            sls_pkg::CSR_FAST_BLINK:   cfg_in.fast_blink_ms   = csr_wdata;
            sls_pkg::CSR_DIM_LEVEL:    cfg_in.dim_level       = csr_wdata[7:0];
            sls_pkg::CSR_BLINK_LEVEL:  cfg_in.blink_level     = csr_wdata[7:0];
            sls_pkg::CSR_FLASH_LEVEL:  cfg_in.flash_level     = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_length_ms <= sls_pkg::RST_FLASH_LENGTH;
         cfg_ff.base_period_ms  <= sls_pkg::RST_BASE_PERIOD;
         cfg_ff.slow_blink_ms   <= sls_pkg::RST_SLOW_BLINK;
         cfg_ff.fast_blink_ms   <= sls_pkg::RST_FAST_BLINK;
         cfg_ff.dim_level       <= sls_pkg::RST_DIM_LEVEL;
         cfg_ff.blink_level     <= sls_pkg::RST_BLINK_LEVEL;
         cfg_ff.flash_level     <= sls_pkg::RST_FLASH_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/sls_engine.sv */
// Sequencer state and the single-pass update logic for one request.
// Depends on sls_pkg.
module sls_engine #(
   parameter int TIMER_BITS    = sls_pkg::TIMER_BITS_DEFAULT,
   parameter int ERROR_TOGGLES = sls_pkg::ERROR_TOGGLES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  sls_pkg::cfg_type cfg,
   input  logic             step_en,
   input  sls_pkg::req_type item,
   output sls_pkg::rsp_type result
);

   localparam int LOAD_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [LOAD_BITS-1:0] TIMER_MAX =
      LOAD_BITS'((64'd1 << TIMER_BITS) - 64'd1);

   function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
      logic [LOAD_BITS-1:0] ext;
      ext = LOAD_BITS'(v);
      timer_load = (ext > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0] : ext[TIMER_BITS-1:0];
   endfunction

   logic [2:0]            mode_ff, mode_in;
   logic                  phase_ff, phase_in;
   logic [2:0]            toggles_ff, toggles_in;
   logic                  flash_ff, flash_in;
   logic                  flash_tx_ff, flash_tx_in;
   logic [TIMER_BITS-1:0] flash_ticks_ff, flash_ticks_in;
   logic [TIMER_BITS-1:0] wait_ff, wait_in;
   logic [23:0]           color_ff, color_in;
   logic                  blink_wait_ff, blink_wait_in;
   logic                  do_update;

   always_comb begin
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      toggles_in     = toggles_ff;
      flash_in       = flash_ff;
      flash_tx_in    = flash_tx_ff;
      flash_ticks_in = flash_ticks_ff;
      wait_in        = wait_ff;
      color_in       = color_ff;
      blink_wait_in  = blink_wait_ff;
      do_update      = 1'b0;

      if (step_en) begin
         if (item.op == sls_pkg::OP_TICK) begin
            if (flash_ticks_ff != '0) flash_ticks_in = flash_ticks_ff - TIMER_BITS'(1);
            if (wait_ff != '0) wait_in = wait_ff - TIMER_BITS'(1);
            do_update = (wait_in == '0);
         end else begin
            case (item.event_code)
               sls_pkg::EV_AP_WAIT: begin
                  mode_in    = sls_pkg::MODE_AP_WAIT;
                  phase_in   = 1'b1;
                  toggles_in = 3'd0;
               end
               sls_pkg::EV_AP_CONN: begin
                  mode_in    = sls_pkg::MODE_AP_CONN;
                  toggles_in = 3'd0;
               end
               sls_pkg::EV_AP_DISC: begin
                  mode_in  = sls_pkg::MODE_AP_WAIT;
                  phase_in = 1'b1;
               end
               sls_pkg::EV_STA_CONNECTING: begin
                  mode_in    = sls_pkg::MODE_STA_CONNECTING;
                  phase_in   = 1'b1;
                  toggles_in = 3'd0;
               end
               sls_pkg::EV_STA_CONN: begin
                  mode_in    = sls_pkg::MODE_STA_CONN;
                  toggles_in = 3'd0;
               end
               sls_pkg::EV_ERROR: begin
                  mode_in    = sls_pkg::MODE_ERROR;
                  toggles_in = 3'(ERROR_TOGGLES);
                  phase_in   = 1'b1;
               end
               default: begin
                  flash_tx_in    = (item.event_code == sls_pkg::EV_TX);
                  flash_in       = 1'b1;
                  flash_ticks_in = timer_load(cfg.flash_length_ms);
               end
            endcase
            // an event cuts a blink wait short
            do_update = blink_wait_ff;
         end

         if (do_update) begin
            if (flash_in && flash_ticks_in == '0) flash_in = 1'b0;
            blink_wait_in = 1'b0;
            if (flash_in) begin
               color_in = sls_pkg::scale_color(
                  flash_tx_in ? sls_pkg::HUE_MAGENTA : sls_pkg::HUE_CYAN, cfg.flash_level);
               wait_in = timer_load(cfg.base_period_ms);
            end else if (mode_in == sls_pkg::MODE_ERROR && toggles_in != 3'd0) begin
               color_in   = phase_in ? sls_pkg::scale_color(sls_pkg::HUE_RED, cfg.blink_level)
                                     : 24'd0;
               phase_in   = !phase_in;
               toggles_in = toggles_in - 3'd1;
               if (toggles_in == 3'd0) color_in = 24'd0;
               wait_in    = timer_load(cfg.base_period_ms);
            end else if (mode_in == sls_pkg::MODE_AP_WAIT ||
                         mode_in == sls_pkg::MODE_STA_CONNECTING) begin
               if (mode_in == sls_pkg::MODE_AP_WAIT) begin
                  color_in = phase_in ? sls_pkg::scale_color(sls_pkg::HUE_BLUE, cfg.blink_level)
                                      : 24'd0;
                  wait_in  = timer_load(cfg.slow_blink_ms);
               end else begin
                  color_in = phase_in ? sls_pkg::scale_color(sls_pkg::HUE_GREEN, cfg.blink_level)
                                      : 24'd0;
                  wait_in  = timer_load(cfg.fast_blink_ms);
               end
               phase_in      = !phase_in;
               blink_wait_in = 1'b1;
            end else begin
               case (mode_in)
                  sls_pkg::MODE_AP_CONN:
                     color_in = sls_pkg::scale_color(sls_pkg::HUE_BLUE, cfg.dim_level);
                  sls_pkg::MODE_ERROR:
                     color_in = sls_pkg::scale_color(sls_pkg::HUE_RED, cfg.blink_level);
                  default:
                     color_in = sls_pkg::scale_color(sls_pkg::HUE_GREEN, cfg.dim_level);
               endcase
               wait_in = timer_load(cfg.base_period_ms);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= sls_pkg::MODE_AP_WAIT;
         phase_ff       <= 1'b0;
         toggles_ff     <= 3'd0;
         flash_ff       <= 1'b0;
         flash_tx_ff    <= 1'b0;
         flash_ticks_ff <= '0;
         wait_ff        <= '0;
         color_ff       <= 24'd0;
         blink_wait_ff  <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         toggles_ff     <= toggles_in;
         flash_ff       <= flash_in;
         flash_tx_ff    <= flash_tx_in;
         flash_ticks_ff <= flash_ticks_in;
         wait_ff        <= wait_in;
         color_ff       <= color_in;
         blink_wait_ff  <= blink_wait_in;
      end
   end

   assign result.red       = color_in[23:16];
   assign result.green     = color_in[15:8];
   assign result.blue      = color_in[7:0];
   assign result.refreshed = step_en & do_update;

endmodule

/* rtl/status_led_sequencer.sv */
// Top level of the status LED sequencer: request register, update engine,
// response register. Depends on sls_pkg, sls_csr and sls_engine.
//
// Usage:
//   The req channel carries one request per item: a 1 ms tick (op = 0) or a
//   status event (op = 1, event_code). Every request yields exactly one
//   response on the rsp channel with the LED color now shown and a flag
//   telling whether this request ran an update step.
//   The csr port writes the seven timing and brightness registers; write
//   them only while no request is in flight.
//   Timing: an accepted request is held in the request register; when the
//   response register is free the engine processes it, and its response is
//   registered in the response register, where rsp_valid shows it.
//   Throughput: one request per cycle while responses are taken; the whole
//   update is one pass of logic between the request and response registers.
//   Stall: when rsp_ready is low the response register holds its item and
//   the request register can still take one more request; req_ready then
//   drops until the response is taken.
//   Reset (synchronous): both registers empty, configuration at its
//   defaults, link mode AP waiting, LED off, first tick runs an update.
module status_led_sequencer #(
   parameter int TIMER_BITS    = sls_pkg::TIMER_BITS_DEFAULT,
   parameter int ERROR_TOGGLES = sls_pkg::ERROR_TOGGLES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sls_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sls_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [sls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sls_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   sls_pkg::cfg_type cfg;
   sls_pkg::req_type item_ff;
   logic             item_valid_ff, item_valid_in;
   sls_pkg::rsp_type result;
   sls_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;

   sls_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   sls_engine #(
      .TIMER_BITS    (TIMER_BITS),
      .ERROR_TOGGLES (ERROR_TOGGLES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (item_ff),
      .result  (result)
   );

   assign advance   = item_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~item_valid_ff | advance;

   assign item_valid_in = (req_valid & req_ready) | (item_valid_ff & ~advance);
   assign rsp_valid_in  = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) item_ff <= req_data;
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/sls_checker.sv */
// Port-level checks for the status LED sequencer, bound to the top level.
// Depends on sls_pkg and status_led_sequencer.
module sls_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sls_pkg::rsp_type rsp_data
);

   logic        seen_ff;
   logic [23:0] last_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
      if (rsp_valid && rsp_ready) begin
         last_color_ff <= {rsp_data.red, rsp_data.green, rsp_data.blue};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_color_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff && !rsp_data.refreshed |->
         {rsp_data.red, rsp_data.green, rsp_data.blue} == last_color_ff)
      else $error("color changed without an update step");

   a_no_red_green: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.red == 8'd0 || rsp_data.green == 8'd0)
      else $error("red and green lit together");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
      else $error("response missing two cycles after request");

endmodule

bind status_led_sequencer sls_checker u_checker (.*);
